// ----- rtl/core/epp_pkg.sv -----
// shared types, constants and helpers for the eeg headset packet parser
package epp_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned POS_W  = 6;
	localparam int unsigned STAT_W = 2;

	localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'hAA;
	localparam logic [BYTE_W-1:0] LEN_BYTE   = 8'h20;
	localparam logic [BYTE_W-1:0] CODE_BYTE  = 8'h02;
	localparam logic [BYTE_W-1:0] TAG_A_BYTE = 8'h83;
	localparam logic [BYTE_W-1:0] TAG_B_BYTE = 8'h18;

	localparam logic [POS_W-1:0] POS_SYNC0      = 6'd0;
	localparam logic [POS_W-1:0] POS_SYNC1      = 6'd1;
	localparam logic [POS_W-1:0] POS_LEN        = 6'd2;
	localparam logic [POS_W-1:0] POS_CODE       = 6'd3;
	localparam logic [POS_W-1:0] POS_QUALITY    = 6'd4;
	localparam logic [POS_W-1:0] POS_TAG_A      = 6'd5;
	localparam logic [POS_W-1:0] POS_TAG_B      = 6'd6;
	localparam logic [POS_W-1:0] POS_BODY_FIRST = 6'd7;
	localparam logic [POS_W-1:0] POS_ATTENTION  = 6'd32;
	localparam logic [POS_W-1:0] POS_BODY_LAST  = 6'd34;
	localparam logic [POS_W-1:0] POS_MEDITATION = 6'd34;
	localparam logic [POS_W-1:0] POS_CHECKSUM   = 6'd35;

	localparam logic [STAT_W-1:0] ST_NONE = 2'd0;
	localparam logic [STAT_W-1:0] ST_GOOD = 2'd1;
	localparam logic [STAT_W-1:0] ST_POOR = 2'd2;

	// byte held in the input register
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
	} in_stage_t;

	function automatic logic is_poor_signal(input logic [BYTE_W-1:0] q);
		logic poor;
		poor = 1'b0;
		case (q) inside
			8'd29, [8'd54:8'd56], [8'd80:8'd82], 8'd107, 8'd200: poor = 1'b1;
			default: poor = 1'b0;
		endcase
		return poor;
	endfunction

endpackage

// ----- rtl/core/epp_in_stage.sv -----
// input register stage of the eeg headset packet parser
module epp_in_stage
	import epp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              take,
	output in_stage_t         stage_s1
);

	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;

	// free when empty or when the held byte moves on this cycle
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
		end
	end

	assign stage_s1.valid = valid_s1;
	assign stage_s1.data  = data_s1;

endmodule

// ----- rtl/core/epp_framer.sv -----
// frame tracking, checksum and result register of the eeg headset packet parser
module epp_framer
	import epp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  in_stage_t         stage_s1,
	output logic              take,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [STAT_W-1:0] status,
	output logic [BYTE_W-1:0] attention,
	output logic [BYTE_W-1:0] meditation
);

	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] quality_q;
	logic [BYTE_W-1:0] att_cand_q;
	logic [BYTE_W-1:0] med_cand_q;
	logic [BYTE_W-1:0] att_held_q;
	logic [BYTE_W-1:0] med_held_q;
	logic              valid_s2;
	logic [STAT_W-1:0] status_s2;

	logic [POS_W-1:0]  pos_d;
	logic [BYTE_W-1:0] sum_d;
	logic [BYTE_W-1:0] quality_d;
	logic [BYTE_W-1:0] att_cand_d;
	logic [BYTE_W-1:0] med_cand_d;
	logic [BYTE_W-1:0] att_held_d;
	logic [BYTE_W-1:0] med_held_d;
	logic [STAT_W-1:0] status_d;
	logic [BYTE_W-1:0] b;
	logic [BYTE_W-1:0] sum_add;

	assign take    = stage_s1.valid && (!valid_s2 || out_ready);
	assign b       = stage_s1.data;
	assign sum_add = sum_q + b;

	always_comb begin
		pos_d      = POS_SYNC0;
		sum_d      = sum_q;
		quality_d  = quality_q;
		att_cand_d = att_cand_q;
		med_cand_d = med_cand_q;
		att_held_d = att_held_q;
		med_held_d = med_held_q;
		status_d   = ST_NONE;
		case (pos_q) inside
			POS_SYNC0: begin
				if (b == SYNC_BYTE) pos_d = POS_SYNC1;
			end
			POS_SYNC1: begin
				if (b == SYNC_BYTE) pos_d = POS_LEN;
			end
			POS_LEN: begin
				if (b == LEN_BYTE) pos_d = POS_CODE;
			end
			POS_CODE: begin
				// sum restarts on every packet
				if (b == CODE_BYTE) begin
					sum_d = b;
					pos_d = POS_QUALITY;
				end
			end
			POS_QUALITY: begin
				quality_d = b;
				sum_d     = sum_add;
				pos_d     = POS_TAG_A;
			end
			POS_TAG_A: begin
				if (b == TAG_A_BYTE) begin
					sum_d = sum_add;
					pos_d = POS_TAG_B;
				end
			end
			POS_TAG_B: begin
				if (b == TAG_B_BYTE) begin
					sum_d = sum_add;
					pos_d = POS_BODY_FIRST;
				end
			end
			[POS_BODY_FIRST:POS_BODY_LAST]: begin
				sum_d = sum_add;
				if (pos_q == POS_ATTENTION) att_cand_d = b;
				if (pos_q == POS_MEDITATION) med_cand_d = b;
				pos_d = pos_q + 1'b1;
			end
			POS_CHECKSUM: begin
				if (~sum_q == b) begin
					if (is_poor_signal(quality_q)) begin
						status_d = ST_POOR;
					end else begin
						att_held_d = att_cand_q;
						med_held_d = med_cand_q;
						status_d   = ST_GOOD;
					end
				end
			end
			default: pos_d = POS_SYNC0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			sum_q      <= '0;
			quality_q  <= '0;
			att_cand_q <= '0;
			med_cand_q <= '0;
			att_held_q <= '0;
			med_held_q <= '0;
		end else if (take) begin
			pos_q      <= pos_d;
			sum_q      <= sum_d;
			quality_q  <= quality_d;
			att_cand_q <= att_cand_d;
			med_cand_q <= med_cand_d;
			att_held_q <= att_held_d;
			med_held_q <= med_held_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= stage_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_s2 <= status_d;
		end
	end

	assign out_valid  = valid_s2;
	assign status     = status_s2;
	assign attention  = att_held_q;
	assign meditation = med_held_q;

endmodule

// ----- rtl/core/eeg_headset_packet_parser_unit.sv -----
// top level of the eeg headset packet parser
//
// usage:
//   input channel: one serial byte per request on data_byte, with in_valid and
//   in_ready; a byte is taken at an edge where both are high
//   output channel: one result per input byte (status, attention, meditation)
//   with out_valid and out_ready
//   status 1 marks a packet with a good checksum and usable signal, status 2 a
//   good packet flagged as poor signal, 0 everything else
//   attention and meditation show the values of the last good packet
// path: an accepted byte is held in the input register, then passes through the
//   frame logic into the result register
// throughput: one byte per cycle while out_ready stays high; the frame position
//   and checksum are computed combinationally between the input and result registers
// stall: when the receiver holds out_ready low the result register keeps its
//   result, the input register can still take one more byte, then in_ready
//   drops until the result is taken
// reset: arst_n clears both valid flags, frame position, checksum and the held
//   attention and meditation values to zero
module eeg_headset_packet_parser_unit
	import epp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] data_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [STAT_W-1:0] status,
	output logic [BYTE_W-1:0] attention,
	output logic [BYTE_W-1:0] meditation
);

	in_stage_t stage_s1;  // byte waiting for the frame logic
	logic      take;      // frame logic consumes the held byte

	epp_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.take      (take),
		.stage_s1  (stage_s1)
	);

	// header match, running checksum, candidate capture and result register
	epp_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.stage_s1   (stage_s1),
		.take       (take),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.attention  (attention),
		.meditation (meditation)
	);

endmodule

// ----- rtl/core/epp_checker.sv -----
// port-level checks for the eeg headset packet parser
module epp_checker
	import epp_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [BYTE_W-1:0] data_byte,
	input logic              out_valid,
	input logic              out_ready,
	input logic [STAT_W-1:0] status,
	input logic [BYTE_W-1:0] attention,
	input logic [BYTE_W-1:0] meditation
);

	// a waiting request keeps its byte until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(data_byte))
		else $error("waiting request changed");

	// only the three defined status codes appear
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_NONE || status == ST_GOOD || status == ST_POOR))
		else $error("status code out of range");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("stalled result changed");

	// held values move only together with a good-packet result
	a_held_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(attention) || !$stable(meditation) |-> out_valid && status == ST_GOOD)
		else $error("held values changed without a good packet");

endmodule

bind eeg_headset_packet_parser_unit epp_checker u_epp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.data_byte  (data_byte),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.attention  (attention),
	.meditation (meditation)
);

// ----- dv/tb_top.sv -----
// self-checking testbench for the eeg headset packet parser unit
module tb_top;
	import epp_pkg::*;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [BYTE_W-1:0] attention;
		logic [BYTE_W-1:0] meditation;
	} frame_result_t;

	// directed row: one byte and the result it must give
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		frame_result_t     result;
	} directed_row_t;

	localparam int unsigned DIRECTED_ROWS = 25;
	localparam int unsigned PHASE_BYTES   = 460;
	localparam int unsigned HOLD_CYCLES   = 80;
	localparam int unsigned DRAIN_CYCLES  = 8;

	// quality values that flag poor signal, and their direct neighbors
	localparam logic [BYTE_W-1:0] POOR_LIST [9] = '{
		8'd29, 8'd54, 8'd55, 8'd56, 8'd80, 8'd81, 8'd82, 8'd107, 8'd200
	};
	localparam logic [BYTE_W-1:0] NEAR_POOR [10] = '{
		8'd28, 8'd30, 8'd53, 8'd57, 8'd79, 8'd83, 8'd106, 8'd108, 8'd199, 8'd201
	};
	localparam logic [POS_W-1:0] HEADER_POS [6] = '{
		POS_SYNC0, POS_SYNC1, POS_LEN, POS_CODE, POS_TAG_A, POS_TAG_B
	};

	localparam frame_result_t IDLE_RESULT = '{status: ST_NONE, attention: 8'h00,
		meditation: 8'h00};

	// nothing completes here, so every byte reports no packet and zero held values
	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{8'h00, IDLE_RESULT},        // all-zero byte straight out of reset
		'{8'hFF, IDLE_RESULT},        // all-ones byte
		'{SYNC_BYTE, IDLE_RESULT},
		'{8'h55, IDLE_RESULT},        // second sync byte wrong
		'{SYNC_BYTE, IDLE_RESULT},
		'{SYNC_BYTE, IDLE_RESULT},
		'{SYNC_BYTE, IDLE_RESULT},    // third sync byte in length slot: dropped
		'{SYNC_BYTE, IDLE_RESULT},
		'{SYNC_BYTE, IDLE_RESULT},
		'{LEN_BYTE, IDLE_RESULT},
		'{SYNC_BYTE, IDLE_RESULT},    // sync byte in code slot: dropped, not re-synced
		'{SYNC_BYTE, IDLE_RESULT},
		'{SYNC_BYTE, IDLE_RESULT},
		'{LEN_BYTE, IDLE_RESULT},
		'{CODE_BYTE, IDLE_RESULT},
		'{8'hFF, IDLE_RESULT},        // quality byte, any value is taken
		'{TAG_A_BYTE, IDLE_RESULT},
		'{8'h00, IDLE_RESULT},        // second tag wrong
		'{SYNC_BYTE, IDLE_RESULT},
		'{SYNC_BYTE, IDLE_RESULT},
		'{LEN_BYTE, IDLE_RESULT},
		'{CODE_BYTE, IDLE_RESULT},
		'{8'h00, IDLE_RESULT},        // quality byte zero
		'{TAG_B_BYTE, IDLE_RESULT},   // first tag wrong
		'{LEN_BYTE, IDLE_RESULT}      // back at the first sync slot, not a sync byte
	};

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [BYTE_W-1:0] data_byte;
	logic              out_valid;
	logic              out_ready;
	logic [STAT_W-1:0] status;
	logic [BYTE_W-1:0] attention;
	logic [BYTE_W-1:0] meditation;

	eeg_headset_packet_parser_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.attention (attention),
		.meditation(meditation)
	);

	// framer state mirrored by the predictor
	logic [POS_W-1:0]  frame_pos     = POS_SYNC0;
	logic [BYTE_W-1:0] frame_sum     = '0;
	logic [BYTE_W-1:0] frame_quality = '0;
	logic [BYTE_W-1:0] att_pending   = '0;
	logic [BYTE_W-1:0] med_pending   = '0;
	logic [BYTE_W-1:0] att_held      = '0;
	logic [BYTE_W-1:0] med_held      = '0;

	frame_result_t     expected_results [$];
	logic [BYTE_W-1:0] stream_bytes [$];
	int unsigned       mismatch_count = 0;
	int unsigned       tx_idle_pct = 0;
	int unsigned       rx_idle_pct = 0;
	bit                hold_request = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop in case the pipeline hangs
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic bit is_low_quality(input logic [BYTE_W-1:0] q);
		return q == 8'd29 || (q >= 8'd54 && q <= 8'd56) || (q >= 8'd80 && q <= 8'd82) ||
			q == 8'd107 || q == 8'd200;
	endfunction

	// advance the framer by one byte and give the result it reports
	function automatic frame_result_t frame_byte(input logic [BYTE_W-1:0] b);
		frame_result_t    r;
		logic [POS_W-1:0] nxt;
		nxt = POS_SYNC0;
		r.status = ST_NONE;
		case (frame_pos)
			POS_SYNC0: nxt = (b == SYNC_BYTE) ? POS_SYNC1 : POS_SYNC0;
			POS_SYNC1: nxt = (b == SYNC_BYTE) ? POS_LEN : POS_SYNC0;
			POS_LEN:   nxt = (b == LEN_BYTE) ? POS_CODE : POS_SYNC0;
			POS_CODE: begin
				// checksum restarts with the code byte of every packet
				if (b == CODE_BYTE) begin
					frame_sum = b;
					nxt = POS_QUALITY;
				end
			end
			POS_QUALITY: begin
				frame_quality = b;
				frame_sum = frame_sum + b;
				nxt = POS_TAG_A;
			end
			POS_TAG_A: begin
				if (b == TAG_A_BYTE) begin
					frame_sum = frame_sum + b;
					nxt = POS_TAG_B;
				end
			end
			POS_TAG_B: begin
				if (b == TAG_B_BYTE) begin
					frame_sum = frame_sum + b;
					nxt = POS_BODY_FIRST;
				end
			end
			POS_CHECKSUM: begin
				if (BYTE_W'(~frame_sum) == b) begin
					if (is_low_quality(frame_quality)) begin
						r.status = ST_POOR;
					end else begin
						att_held = att_pending;
						med_held = med_pending;
						r.status = ST_GOOD;
					end
				end
			end
			default: begin
				if (frame_pos >= POS_BODY_FIRST && frame_pos < POS_CHECKSUM) begin
					frame_sum = frame_sum + b;
					if (frame_pos == POS_ATTENTION)
						att_pending = b;
					if (frame_pos == POS_MEDITATION)
						med_pending = b;
					nxt = frame_pos + 1'b1;
				end
			end
		endcase
		frame_pos = nxt;
		r.attention = att_held;
		r.meditation = med_held;
		return r;
	endfunction

	// offer one byte, wait for it to be taken, then queue its expected result
	task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed,
		input frame_result_t typed_result);
		frame_result_t r;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = frame_byte(b);
		expected_results.push_back(typed ? typed_result : r);
	endtask

	function automatic logic [BYTE_W-1:0] pick_quality();
		int unsigned r;
		r = $urandom_range(9);
		if (r < 4)
			return POOR_LIST[$urandom_range(8)];
		if (r < 6)
			return NEAR_POOR[$urandom_range(9)];
		if (r == 6)
			return $urandom_range(1) ? 8'hFF : 8'h00;
		return BYTE_W'($urandom);
	endfunction

	// append one chunk of stream: line noise, a clean packet, a packet with
	// a bad checksum, or a packet with a broken header
	task automatic add_segment();
		logic [BYTE_W-1:0] pkt [36];
		logic [BYTE_W-1:0] sum;
		int unsigned       kind;
		int unsigned       n;
		kind = $urandom_range(99);
		if (kind < 15) begin
			n = $urandom_range(1, 12);
			repeat (n)
				stream_bytes.push_back($urandom_range(3) == 0 ? SYNC_BYTE : BYTE_W'($urandom));
		end else begin
			pkt[POS_SYNC0] = SYNC_BYTE;
			pkt[POS_SYNC1] = SYNC_BYTE;
			pkt[POS_LEN] = LEN_BYTE;
			pkt[POS_CODE] = CODE_BYTE;
			pkt[POS_QUALITY] = pick_quality();
			pkt[POS_TAG_A] = TAG_A_BYTE;
			pkt[POS_TAG_B] = TAG_B_BYTE;
			for (int i = POS_BODY_FIRST; i < POS_CHECKSUM; i++)
				pkt[i] = BYTE_W'($urandom);
			// push the held values to their extremes now and then
			if ($urandom_range(7) == 0)
				pkt[POS_ATTENTION] = $urandom_range(1) ? 8'hFF : 8'h00;
			if ($urandom_range(7) == 0)
				pkt[POS_MEDITATION] = $urandom_range(1) ? 8'hFF : 8'h00;
			sum = '0;
			for (int i = POS_CODE; i < POS_CHECKSUM; i++)
				sum = sum + pkt[i];
			pkt[POS_CHECKSUM] = ~sum;
			if (kind < 27)
				pkt[POS_CHECKSUM] ^= BYTE_W'($urandom_range(1, 255));
			else if (kind < 38)
				pkt[HEADER_POS[$urandom_range(5)]] ^= BYTE_W'($urandom_range(1, 255));
			foreach (pkt[i])
				stream_bytes.push_back(pkt[i]);
		end
	endtask

	// result side: random back-pressure, one long hold on request, and the compare
	initial begin : result_side
		frame_result_t exp_r;
		int unsigned   hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: status %0d attention %0d meditation %0d",
						status, attention, meditation);
					mismatch_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (status !== exp_r.status) begin
						$error("status: expected %0d, got %0d", exp_r.status, status);
						mismatch_count++;
					end
					if (attention !== exp_r.attention) begin
						$error("attention: expected %0d, got %0d", exp_r.attention, attention);
						mismatch_count++;
					end
					if (meditation !== exp_r.meditation) begin
						$error("meditation: expected %0d, got %0d", exp_r.meditation,
							meditation);
						mismatch_count++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_request) begin
				// long stall so the input side fills up and drops in_ready
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// request side: reset, directed bytes, then three phases of random stream
	initial begin : request_side
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 34;
		rx_idle_pct = 69;
		foreach (DIRECTED[i])
			send_byte(DIRECTED[i].data, 1'b1, DIRECTED[i].result);

		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				// swap the idle rates, after letting every pending result out
				in_valid <= 1'b0;
				wait (expected_results.size() == 0);
				@(posedge clk);
				tx_idle_pct = 69;
				rx_idle_pct = 34;
			end
			if (phase == 2) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
				hold_request = 1'b1;
			end
			stream_bytes.delete();
			while (stream_bytes.size() < PHASE_BYTES)
				add_segment();
			foreach (stream_bytes[i])
				send_byte(stream_bytes[i], 1'b0, IDLE_RESULT);
		end
		in_valid <= 1'b0;

		// let the pipeline empty, then watch for strays
		wait (expected_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
